[rtl/pcxrle_pkg.sv]
// Shared types and constants of the PCX run-length decoder.
// Used by the interfaces, the register block, the controller and the datapath.
package pcxrle_pkg;

  // Widths of the payload fields and of the internal counters.
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned DimWidth   = 16;
  localparam int unsigned ProdWidth  = 2 * DimWidth;
  localparam int unsigned SizeWidth  = ProdWidth + 2;
  localparam int unsigned RunWidth   = 6;
  localparam int unsigned AddrWidth  = 3;
  localparam int unsigned DataWidth  = 32;

  // Top two bits of a run header byte.
  localparam logic [1:0] HeaderCode = 2'b11;

  // Register indexes on the configuration port.
  localparam logic RegWidthIdx  = 1'b0;
  localparam logic RegHeightIdx = 1'b1;

  // Cycles the image size pipeline needs after a register write.
  localparam logic [1:0] SizeSettleCycles = 2'd3;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    S_ACCEPT = 4'b0001,
    S_WAIT   = 4'b0010,
    S_RUN    = 4'b0100,
    S_DONE   = 4'b1000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_run;      // capture the run count of a header byte
    logic load_value;    // capture the run value byte and its end flag
    logic emit_literal;  // send the input byte as one result
    logic emit_run;      // send one byte of the current run
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_header;      // input byte is a run header
    logic in_last;        // input byte ends the stream
    logic full;           // image already holds all its bytes
    logic next_complete;  // the next byte sent fills the image
    logic run_zero;       // captured run count is zero
    logic run_end;        // the next run byte is the final one
    logic saved_last;     // the run value byte ended the stream
    logic out_free;       // output register can take a byte this cycle
    logic size_busy;      // image size is being recomputed
  } status_t;

endpackage

[rtl/pcxrle_if.sv]
// Valid/ready channel interfaces of the PCX run-length decoder.
// Depends on pcxrle_pkg for the field widths.
interface pcxrle_in_if;
  logic                               valid;
  logic                               ready;
  logic [pcxrle_pkg::ByteWidth-1:0]   data_byte;
  logic                               end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface pcxrle_out_if;
  logic                               valid;
  logic                               ready;
  logic [pcxrle_pkg::ByteWidth-1:0]   pixel_byte;
  logic                               last_of_run;
  logic                               image_complete;

  modport source (output valid, output pixel_byte, output last_of_run,
                  output image_complete, input ready);
  modport sink (input valid, input pixel_byte, input last_of_run,
                input image_complete, output ready);
endinterface

[rtl/pcxrle_cfg.sv]
// Configuration registers of the PCX decoder and the image size pipeline.
// Depends on pcxrle_pkg; driven by the APB-style port of the top level.
module pcxrle_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pcxrle_pkg::AddrWidth-1:0]    paddr,
  input  logic [pcxrle_pkg::DataWidth-1:0]    pwdata,
  output logic [pcxrle_pkg::DataWidth-1:0]    prdata,
  output logic                                pready,
  output logic [pcxrle_pkg::SizeWidth-1:0]    total_o,
  output logic [pcxrle_pkg::SizeWidth-1:0]    total_m1_o,
  output logic                                busy_o
);

  logic [pcxrle_pkg::DimWidth-1:0]  width_q, width_d;
  logic [pcxrle_pkg::DimWidth-1:0]  height_q, height_d;
  logic [pcxrle_pkg::ProdWidth-1:0] prod_q, prod_d;
  logic [pcxrle_pkg::SizeWidth-1:0] total_q, total_d;
  logic [pcxrle_pkg::SizeWidth-1:0] total_m1_q, total_m1_d;
  logic [1:0]                       settle_q, settle_d;
  logic                             wr_en;
  logic                             reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite;

  // Register writes.
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en && (reg_idx == pcxrle_pkg::RegWidthIdx)) begin
      width_d = pwdata[pcxrle_pkg::DimWidth-1:0];
    end
    if (wr_en && (reg_idx == pcxrle_pkg::RegHeightIdx)) begin
      height_d = pwdata[pcxrle_pkg::DimWidth-1:0];
    end
  end

  // Register reads return the value zero-extended.
  always_comb begin
    prdata = '0;
    if (reg_idx == pcxrle_pkg::RegWidthIdx) begin
      prdata[pcxrle_pkg::DimWidth-1:0] = width_q;
    end else begin
      prdata[pcxrle_pkg::DimWidth-1:0] = height_q;
    end
  end

  // Image size in bytes: width times height, then times three; the size minus one is also kept.
  assign prod_d     = width_q * height_q;
  assign total_d    = {2'b00, prod_q} + {1'b0, prod_q, 1'b0};
  assign total_m1_d = total_q - pcxrle_pkg::SizeWidth'(1);

  // The size is stale for a few cycles after any write.
  always_comb begin
    settle_d = settle_q;
    if (wr_en) begin
      settle_d = pcxrle_pkg::SizeSettleCycles;
    end else if (settle_q != 2'd0) begin
      settle_d = settle_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= pcxrle_pkg::DimWidth'(1);
      height_q   <= pcxrle_pkg::DimWidth'(1);
      prod_q     <= pcxrle_pkg::ProdWidth'(1);
      total_q    <= pcxrle_pkg::SizeWidth'(3);
      total_m1_q <= pcxrle_pkg::SizeWidth'(2);
      settle_q   <= 2'd0;
    end else begin
      width_q    <= width_d;
      height_q   <= height_d;
      prod_q     <= prod_d;
      total_q    <= total_d;
      total_m1_q <= total_m1_d;
      settle_q   <= settle_d;
    end
  end

  assign total_o    = total_q;
  assign total_m1_o = total_m1_q;
  assign busy_o     = (settle_q != 2'd0);

endmodule

[rtl/pcxrle_dp.sv]
// Datapath of the PCX decoder: run counter, byte count and output register.
// Depends on pcxrle_pkg and the channel interfaces; commanded by pcxrle_ctrl.
module pcxrle_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [pcxrle_pkg::ByteWidth-1:0]  data_byte_i,
  input  logic                              end_of_input_i,
  input  logic [pcxrle_pkg::SizeWidth-1:0]  total_i,
  input  logic [pcxrle_pkg::SizeWidth-1:0]  total_m1_i,
  input  logic                              size_busy_i,
  input  pcxrle_pkg::cmd_t                  cmd_i,
  output pcxrle_pkg::status_t               status_o,
  pcxrle_out_if.source                      out_o
);

  logic [pcxrle_pkg::RunWidth-1:0]  run_q, run_d;
  logic [pcxrle_pkg::ByteWidth-1:0] value_q, value_d;
  logic                             saved_last_q, saved_last_d;
  logic [pcxrle_pkg::SizeWidth-1:0] written_q, written_d;
  logic                             out_valid_q, out_valid_d;
  logic [pcxrle_pkg::ByteWidth-1:0] out_byte_q, out_byte_d;
  logic                             out_last_q, out_last_d;
  logic                             out_cmpl_q, out_cmpl_d;
  logic                             next_complete;
  logic                             run_end;
  logic                             emit;

  assign next_complete = (written_q == total_m1_i);
  assign run_end       = (run_q == pcxrle_pkg::RunWidth'(1)) | next_complete;
  assign emit          = cmd_i.emit_literal | cmd_i.emit_run;

  // Status toward the controller.
  always_comb begin
    status_o.in_header     = (data_byte_i[7:6] == pcxrle_pkg::HeaderCode);
    status_o.in_last       = end_of_input_i;
    status_o.full          = (written_q >= total_i);
    status_o.next_complete = next_complete;
    status_o.run_zero      = (run_q == '0);
    status_o.run_end       = run_end;
    status_o.saved_last    = saved_last_q;
    status_o.out_free      = ~out_valid_q | out_o.ready;
    status_o.size_busy     = size_busy_i;
  end

  // Run count and run value.
  always_comb begin
    run_d        = run_q;
    value_d      = value_q;
    saved_last_d = saved_last_q;
    if (cmd_i.load_run) begin
      run_d = data_byte_i[pcxrle_pkg::RunWidth-1:0];
    end else if (cmd_i.emit_run) begin
      run_d = run_q - pcxrle_pkg::RunWidth'(1);
    end
    if (cmd_i.load_value) begin
      value_d      = data_byte_i;
      saved_last_d = end_of_input_i;
    end
  end

  // Byte count and output register.
  always_comb begin
    written_d   = written_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_cmpl_d  = out_cmpl_q;
    if (emit) begin
      written_d   = written_q + pcxrle_pkg::SizeWidth'(1);
      out_valid_d = 1'b1;
      out_cmpl_d  = next_complete;
      if (cmd_i.emit_literal) begin
        out_byte_d = data_byte_i;
        out_last_d = 1'b1;
      end else begin
        out_byte_d = value_q;
        out_last_d = run_end;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q        <= '0;
      saved_last_q <= 1'b0;
      written_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      run_q        <= run_d;
      saved_last_q <= saved_last_d;
      written_q    <= written_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q    <= value_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_cmpl_q <= out_cmpl_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.pixel_byte     = out_byte_q;
  assign out_o.last_of_run    = out_last_q;
  assign out_o.image_complete = out_cmpl_q;

endmodule

[rtl/pcxrle_ctrl.sv]
// Controller state machine of the PCX decoder.
// Depends on pcxrle_pkg; drives the input ready and commands pcxrle_dp.
module pcxrle_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pcxrle_pkg::status_t  status_i,
  output pcxrle_pkg::cmd_t     cmd_o
);

  pcxrle_pkg::state_e state_q, state_d;
  logic               in_fire;

  // Input ready: ignored input is always taken once decoding has ended.
  always_comb begin
    case (state_q)
      pcxrle_pkg::S_ACCEPT,
      pcxrle_pkg::S_WAIT:   in_ready_o = status_i.out_free & ~status_i.size_busy;
      pcxrle_pkg::S_DONE:   in_ready_o = 1'b1;
      default:              in_ready_o = 1'b0;
    endcase
  end

  assign in_fire = in_valid_i & in_ready_o;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      pcxrle_pkg::S_ACCEPT: begin
        if (in_fire) begin
          if (status_i.full) begin
            state_d = pcxrle_pkg::S_DONE;
          end else if (!status_i.in_header) begin
            cmd_o.emit_literal = 1'b1;
            if (status_i.in_last || status_i.next_complete) begin
              state_d = pcxrle_pkg::S_DONE;
            end
          end else if (status_i.in_last) begin
            state_d = pcxrle_pkg::S_DONE;
          end else begin
            cmd_o.load_run = 1'b1;
            state_d        = pcxrle_pkg::S_WAIT;
          end
        end
      end
      pcxrle_pkg::S_WAIT: begin
        if (in_fire) begin
          if (status_i.full) begin
            state_d = pcxrle_pkg::S_DONE;
          end else if (status_i.run_zero) begin
            state_d = status_i.in_last ? pcxrle_pkg::S_DONE : pcxrle_pkg::S_ACCEPT;
          end else begin
            cmd_o.load_value = 1'b1;
            state_d          = pcxrle_pkg::S_RUN;
          end
        end
      end
      pcxrle_pkg::S_RUN: begin
        if (status_i.out_free) begin
          cmd_o.emit_run = 1'b1;
          if (status_i.run_end) begin
            if (status_i.saved_last || status_i.next_complete) begin
              state_d = pcxrle_pkg::S_DONE;
            end else begin
              state_d = pcxrle_pkg::S_ACCEPT;
            end
          end
        end
      end
      pcxrle_pkg::S_DONE: begin
        state_d = pcxrle_pkg::S_DONE;
      end
      default: begin
        state_d = pcxrle_pkg::S_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcxrle_pkg::S_ACCEPT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/pcx_rle_decoder.sv]
// PCX run-length decoder: one encoded byte in per transaction, decoded bytes out.
// Channel inputs arrive on pcxrle_in_if, results leave on pcxrle_out_if; the
// image size is set through a small APB-style register port.
// A literal byte (top two bits not both set) gives one output byte in the
// cycle after it is accepted, and literals pass at one per cycle while the output is free.
// A run header byte gives no output; its count N is applied to the next byte.
// That value byte is accepted, then N output bytes follow at one per cycle while
// the receiver keeps up, and input is held off until the run is out.
// The output register and the run counter set this rate.
// Output stops after width * 3 * height bytes; the byte that fills the image
// has image_complete set, and every later input transaction is taken and
// dropped. A header on the final input byte ends decoding with no output.
// After a register write, an active decoder holds input off while the size
// multiplier pipeline settles. Reset restores a one-by-one image and an empty
// decoder; decoding restarts only after reset.
// When the receiver stalls, the output register holds its byte and input is
// held off until the byte is taken.
// Depends on pcxrle_pkg, the channel interfaces, pcxrle_cfg, pcxrle_ctrl, pcxrle_dp.
module pcx_rle_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  pcxrle_in_if.sink                         in_i,
  pcxrle_out_if.source                      out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pcxrle_pkg::AddrWidth-1:0]  paddr,
  input  logic [pcxrle_pkg::DataWidth-1:0]  pwdata,
  output logic [pcxrle_pkg::DataWidth-1:0]  prdata,
  output logic                              pready
);

  logic [pcxrle_pkg::SizeWidth-1:0] total;
  logic [pcxrle_pkg::SizeWidth-1:0] total_m1;
  logic                             size_busy;
  pcxrle_pkg::cmd_t                 cmd;
  pcxrle_pkg::status_t              status;

  // Registers and image size.
  pcxrle_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .total_o    (total),
    .total_m1_o (total_m1),
    .busy_o     (size_busy)
  );

  // Sequencing of headers, runs and literals.
  pcxrle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Counters and output register.
  pcxrle_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_byte_i    (in_i.data_byte),
    .end_of_input_i (in_i.end_of_input),
    .total_i        (total),
    .total_m1_i     (total_m1),
    .size_busy_i    (size_busy),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_o          (out_o)
  );

endmodule

[sim/pcx_rle_decoder_checker.sv]
`timescale 1ns / 100ps
// Checker of the PCX run-length decoder: watches both channels and the register port.
// It predicts the decoded bytes and compares every output transaction with them.
// Depends on pcxrle_pkg and the channel interfaces in pcxrle_if.
module pcx_rle_decoder_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  pcxrle_in_if                              in_mon_i,
  pcxrle_out_if                             out_mon_i,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pcxrle_pkg::AddrWidth-1:0]  paddr,
  input  logic [pcxrle_pkg::DataWidth-1:0]  pwdata,
  input  logic                              pready,
  output int unsigned                       error_count_o,
  output int unsigned                       pending_o
);
  import pcxrle_pkg::*;

  // One decoded byte as it should leave the block.
  typedef struct packed {
    logic [ByteWidth-1:0] pixel_byte;
    logic                 last_of_run;
    logic                 image_complete;
  } pixel_result_t;

  pixel_result_t        pixel_q[$];

  // Shadow of the size registers and of the decoder state.
  logic [DimWidth-1:0]  img_width;
  logic [DimWidth-1:0]  img_height;
  logic                 run_pending;
  logic [RunWidth-1:0]  run_count;
  logic [SizeWidth-1:0] bytes_out;
  logic                 stream_done;

  initial begin
    error_count_o = 0;
    pending_o     = 0;
  end

  task automatic push_pixel(input logic [ByteWidth-1:0] value, input logic last,
                            input logic complete);
    pixel_result_t r;
    r.pixel_byte     = value;
    r.last_of_run    = last;
    r.image_complete = complete;
    pixel_q.push_back(r);
  endtask

  // Decodes one accepted input byte and queues the bytes it must produce.
  task automatic decode_byte(input logic [ByteWidth-1:0] in_byte, input logic in_last);
    logic [SizeWidth-1:0] img_size;
    logic [SizeWidth-1:0] room;
    logic [RunWidth:0]    count;
    img_size = img_width * 34'd3 * img_height;
    if (stream_done) return;
    // A size at or below what was already written ends decoding silently.
    if (bytes_out >= img_size) begin
      stream_done = 1'b1;
      return;
    end
    room = img_size - bytes_out;
    if (run_pending) begin
      // Value byte of a run, cut short where the image fills up.
      run_pending = 1'b0;
      count = {1'b0, run_count};
      if (count > room) count = room[RunWidth:0];
      for (int i = 0; i < count; i++) begin
        bytes_out = bytes_out + SizeWidth'(1);
        push_pixel(in_byte, (i + 1) == count, bytes_out == img_size);
      end
    end else if (in_byte[7:6] != HeaderCode) begin
      bytes_out = bytes_out + SizeWidth'(1);
      push_pixel(in_byte, 1'b1, bytes_out == img_size);
    end else begin
      // A run header on the final byte has nothing to repeat.
      if (in_last) begin
        stream_done = 1'b1;
        return;
      end
      run_pending = 1'b1;
      run_count   = in_byte[RunWidth-1:0];
    end
    if (in_last || bytes_out >= img_size) stream_done = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_result_t want;
    if (!rst_ni) begin
      img_width   = DimWidth'(1);
      img_height  = DimWidth'(1);
      run_pending = 1'b0;
      run_count   = '0;
      bytes_out   = '0;
      stream_done = 1'b0;
      pixel_q.delete();
    end else begin
      // Register writes take effect for the inputs that follow.
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == RegWidthIdx) img_width = pwdata[DimWidth-1:0];
        else img_height = pwdata[DimWidth-1:0];
      end
      if (in_mon_i.valid && in_mon_i.ready)
        decode_byte(in_mon_i.data_byte, in_mon_i.end_of_input);
      // Each output transaction is matched against the oldest prediction.
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (pixel_q.size() == 0) begin
          $error("unexpected result: pixel_byte %0h last_of_run %0b image_complete %0b",
                 out_mon_i.pixel_byte, out_mon_i.last_of_run, out_mon_i.image_complete);
          error_count_o++;
        end else begin
          want = pixel_q.pop_front();
          if (out_mon_i.pixel_byte !== want.pixel_byte) begin
            $error("pixel_byte mismatch: expected %0h, actual %0h",
                   want.pixel_byte, out_mon_i.pixel_byte);
            error_count_o++;
          end
          if (out_mon_i.last_of_run !== want.last_of_run) begin
            $error("last_of_run mismatch: expected %0b, actual %0b",
                   want.last_of_run, out_mon_i.last_of_run);
            error_count_o++;
          end
          if (out_mon_i.image_complete !== want.image_complete) begin
            $error("image_complete mismatch: expected %0b, actual %0b",
                   want.image_complete, out_mon_i.image_complete);
            error_count_o++;
          end
        end
      end
    end
    pending_o = pixel_q.size();
  end

endmodule

[sim/pcx_rle_decoder_tb.sv]
`timescale 1ns / 100ps
// Testbench top of the PCX run-length decoder: clock, reset, stimulus and verdict.
// Depends on pcxrle_pkg, pcxrle_if, pcx_rle_decoder and pcx_rle_decoder_checker.
module pcx_rle_decoder_tb;
  import pcxrle_pkg::*;

  localparam logic [AddrWidth-1:0] WidthAddr   = {RegWidthIdx, 2'b00};
  localparam logic [AddrWidth-1:0] HeightAddr  = {RegHeightIdx, 2'b00};
  localparam int unsigned          SegItems    = 115;
  localparam int unsigned          HoldCycles  = 400;
  localparam logic [RunWidth-1:0]  MaxRun      = 6'h3F;

  // Ways the single encoded stream of the run is brought to its end.
  typedef enum int {EndCutRun, EndHeaderLast, EndShrink, EndRunLast} stream_end_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;
  int unsigned          error_count;
  int unsigned          pending;
  int unsigned          burst_left;
  int unsigned          pixels_taken;
  logic                 hold_req;
  logic                 hold_taken;
  int unsigned          hold_left;
  int unsigned          stall_mode;
  int unsigned          mode_left;
  int unsigned          stall_phase;

  pcxrle_in_if  in_if ();
  pcxrle_out_if out_if ();

  pcx_rle_decoder DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pcx_rle_decoder_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon_i      (in_if),
    .out_mon_i     (out_if),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  always #6 clk_i = ~clk_i;

  // Decoded bytes taken so far; the final image size is chosen from this.
  initial pixels_taken = 0;
  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) pixels_taken++;
  end

  // Receiver: changing stall patterns, plus one long hold-off on request.
  initial begin
    hold_left   = 0;
    hold_taken  = 1'b0;
    stall_mode  = 0;
    mode_left   = 0;
    stall_phase = 0;
  end
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken   <= 1'b1;
      hold_left    <= HoldCycles;
      out_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(5, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      stall_phase <= stall_phase + 1;
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= 1'($urandom_range(0, 1));
        2: out_if.ready <= ($urandom_range(0, 7) != 0);
        default: out_if.ready <= (stall_phase % 3 == 0);
      endcase
    end
  end

  // Offers one byte and waits for its transaction; the sender idles between bursts.
  task automatic send_byte(input logic [ByteWidth-1:0] value, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    in_if.valid        <= 1'b1;
    in_if.data_byte    <= value;
    in_if.end_of_input <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
  endtask

  task automatic send_run(input logic [RunWidth-1:0] count, input logic [ByteWidth-1:0] value,
                          input logic last);
    send_byte({HeaderCode, count}, 1'b0);
    send_byte(value, last);
  endtask

  // Stops offering input and lets every predicted byte come out.
  task automatic drain();
    in_if.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [AddrWidth-1:0] addr, input logic [DataWidth-1:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly literals and well-formed runs, some raw bytes; the stream is never ended here.
  task automatic random_items(input int unsigned n);
    int unsigned          sel;
    logic [RunWidth-1:0]  count;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        send_byte(ByteWidth'($urandom_range(0, 191)), 1'b0);
      end else if (sel < 85) begin
        count = ($urandom_range(0, 3) == 0) ? RunWidth'($urandom_range(0, 3))
                                            : RunWidth'($urandom_range(0, 63));
        send_run(count, ByteWidth'($urandom_range(0, 255)), 1'b0);
      end else begin
        send_byte(ByteWidth'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  // Limit on the whole run.
  initial begin
    #10ms;
    $display("pcx_rle_decoder verification failed");
    $finish;
  end

  initial begin
    stream_end_e end_case;
    in_if.valid        = 1'b0;
    in_if.data_byte    = '0;
    in_if.end_of_input = 1'b0;
    out_if.ready       = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    rst_ni             = 1'b0;
    hold_req           = 1'b0;
    burst_left         = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: largest image, literal edges and runs of every kind.
    write_reg(WidthAddr, 32'hFFFF);
    write_reg(HeightAddr, 32'hFFFF);
    send_byte(8'h00, 1'b0);
    send_byte(8'h3F, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_run(6'h00, 8'h55, 1'b0);
    send_run(6'h01, 8'hFF, 1'b0);
    send_run(MaxRun, 8'h00, 1'b0);
    send_run(6'h03, 8'hC7, 1'b0);
    send_run(6'h02, 8'h80, 1'b0);
    drain();

    // Random part over three image shapes; the long hold-off falls in the second.
    write_reg(WidthAddr, 32'd1);
    random_items(SegItems);
    drain();
    write_reg(WidthAddr, 32'hFFFF);
    write_reg(HeightAddr, 32'd1);
    hold_req = 1'b1;
    random_items(SegItems);
    drain();
    write_reg(WidthAddr, $urandom_range(8000, 65535));
    write_reg(HeightAddr, $urandom_range(1, 65535));
    random_items(SegItems);
    drain();

    // End the stream one way, then offer bytes that must all be dropped.
    end_case = stream_end_e'($urandom_range(0, 3));
    case (end_case)
      EndCutRun: begin
        write_reg(WidthAddr, 32'd1);
        write_reg(HeightAddr, pixels_taken / 3 + $urandom_range(1, 20));
        send_byte(ByteWidth'($urandom_range(0, 191)), 1'b0);
        send_run(MaxRun, ByteWidth'($urandom_range(0, 255)), 1'b0);
      end
      EndHeaderLast: send_byte({HeaderCode, 6'($urandom_range(0, 63))}, 1'b1);
      EndShrink: begin
        write_reg(WidthAddr, 32'd1);
        write_reg(HeightAddr, 32'd1);
        send_byte(ByteWidth'($urandom_range(0, 255)), 1'b0);
      end
      default: send_run(RunWidth'($urandom_range(1, 63)), ByteWidth'($urandom_range(0, 255)),
                        1'b1);
    endcase
    for (int i = 0; i < 12; i++) begin
      send_byte(ByteWidth'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end

    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (error_count == 0) begin
      $display("pcx_rle_decoder verification clean");
    end else begin
      $display("pcx_rle_decoder verification failed");
    end
    $finish;
  end

endmodule
